/* src/rasb_pkg.sv */
package rasb_pkg;

    // Sizes of the point store and the bucket table.
    localparam int MAX_POINTS  = 4096;
    localparam int MAX_RINGS   = 64;
    localparam int NUM_BUCKETS = 2 * MAX_RINGS;
    localparam int PT_AW       = $clog2(MAX_POINTS);
    localparam int BK_AW       = $clog2(NUM_BUCKETS);
    localparam int CNT_W       = PT_AW + 1;

    // Command codes.
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_FIN  = 2'd1;
    localparam logic [1:0] CMD_POS  = 2'd2;
    localparam logic [1:0] CMD_BKT  = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DROP = 2'd2;
    localparam logic [1:0] ST_BAD  = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [5:0]  ring;
        logic        angle_positive;
        logic [63:0] payload;
        logic [11:0] position;
        logic [6:0]  bucket;
    } t_in_item;

    typedef struct packed {
        logic [63:0] point_data;
        logic [6:0]  point_bucket;
        logic [12:0] range_start;
        logic [12:0] range_end;
        logic [12:0] total_points;
        logic [1:0]  status;
    } t_out_item;

    // Command class worked out by the front end.
    typedef struct packed {
        logic is_load;
        logic is_fin;
        logic is_pos;
        logic is_bkt;
    } t_cls;

    typedef struct packed {
        t_cls     cls;
        t_in_item item;
    } t_q_entry;

endpackage

/* src/rasb_ram.sv */
module rasb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/rasb_front.sv */
module rasb_front import rasb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    output logic     o_q_valid,
    input  logic     i_q_pop,
    output t_q_entry o_q_entry
);

    t_q_entry   r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_q_entry   w_entry;
    logic       w_push;
    logic       w_pop;

    // Classify the command as it enters the queue.
    always_comb begin
        w_entry.item        = i_in_item;
        w_entry.cls.is_load = (i_in_item.command == CMD_LOAD);
        w_entry.cls.is_fin  = (i_in_item.command == CMD_FIN);
        w_entry.cls.is_pos  = (i_in_item.command == CMD_POS);
        w_entry.cls.is_bkt  = (i_in_item.command == CMD_BKT);
    end

    assign o_in_ready = (r_cnt != 2'd2);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_entry  = r_mem[r_rp];
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = i_q_pop && o_q_valid;

    // Two-entry queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_entry;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

/* src/rasb_back.sv */
module rasb_back import rasb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [6:0] i_cfg_data,
    input  logic      i_q_valid,
    output logic      o_q_pop,
    input  t_q_entry  i_q_entry,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    typedef enum logic [16:0] {
        S_IDLE     = 17'h00001,
        S_CLR      = 17'h00002,
        S_CNT_KEY  = 17'h00004,
        S_CNT_FILL = 17'h00008,
        S_CNT_WR   = 17'h00010,
        S_PFX_RD   = 17'h00020,
        S_PFX_WR   = 17'h00040,
        S_SCT_KEY  = 17'h00080,
        S_SCT_FILL = 17'h00100,
        S_SCT_WR   = 17'h00200,
        S_FIN      = 17'h00400,
        S_POS_IDX  = 17'h00800,
        S_POS_DATA = 17'h01000,
        S_BK_A     = 17'h02000,
        S_BK_B     = 17'h04000,
        S_SPARE0   = 17'h08000,
        S_SPARE1   = 17'h10000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [6:0]        r_rings;
    logic [CNT_W-1:0]  r_load_cnt;
    logic [CNT_W-1:0]  r_sorted_total;
    logic [1:0]        r_flags;
    logic              r_bounds_valid;
    logic [CNT_W-1:0]  r_idx;
    logic [BK_AW-1:0]  r_b;
    logic [BK_AW-1:0]  r_k;
    logic [CNT_W-1:0]  r_run;
    logic [CNT_W-1:0]  r_start;
    t_in_item          r_item;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [6:0]        w_eff;
    logic [7:0]        w_nb;
    logic              w_slot;
    logic              w_emit;
    t_out_item         w_res;
    t_in_item          w_in;
    logic [BK_AW-1:0]  w_key_new;

    // RAM ports.
    logic              pt_we, pt_re, ks_we, ks_re, si_we, si_re;
    logic              fl_we, fl_re, bb_we, bb_re;
    logic [PT_AW-1:0]  pt_waddr, pt_raddr, ks_raddr, si_waddr, si_raddr;
    logic [63:0]       pt_rdata;
    logic [BK_AW-1:0]  ks_rdata;
    logic [PT_AW-1:0]  si_rdata;
    logic [BK_AW-1:0]  fl_waddr, fl_raddr, bb_raddr;
    logic [CNT_W-1:0]  fl_wdata, fl_rdata, bb_wdata, bb_rdata;

    assign o_cfg_ready = 1'b1;
    assign w_in        = i_q_entry.item;
    assign w_eff       = (r_rings > 7'(MAX_RINGS)) ? 7'(MAX_RINGS) : r_rings;
    assign w_nb        = {w_eff, 1'b0};
    assign w_slot      = !r_out_valid || i_out_ready;
    assign w_key_new   = {w_in.ring, ~w_in.angle_positive};
    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid && w_slot;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign pt_waddr = r_load_cnt[PT_AW-1:0];
    assign pt_raddr = si_rdata;
    assign ks_raddr = (r_state == S_POS_IDX) ? si_rdata : r_idx[PT_AW-1:0];
    assign si_raddr = w_in.position;
    assign si_waddr = fl_rdata[PT_AW-1:0];
    assign fl_raddr = (r_state == S_PFX_RD) ? r_b : ks_rdata;
    assign bb_raddr = (r_state == S_BK_A) ? r_item.bucket : (w_in.bucket - 7'd1);
    assign bb_wdata = r_run + fl_rdata;

    // Write and read strobes of the stores, and the result of each command.
    always_comb begin
        pt_we    = 1'b0;
        ks_we    = 1'b0;
        pt_re    = 1'b0;
        ks_re    = 1'b0;
        si_we    = 1'b0;
        si_re    = 1'b0;
        fl_we    = 1'b0;
        fl_re    = 1'b0;
        bb_we    = 1'b0;
        bb_re    = 1'b0;
        fl_waddr = r_b;
        fl_wdata = '0;
        w_emit   = 1'b0;
        w_res    = '0;
        n_state  = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_q_pop) begin
                    if (i_q_entry.cls.is_load) begin
                        w_emit = 1'b1;
                        if (r_load_cnt >= CNT_W'(MAX_POINTS)) begin
                            w_res.status = ST_OVF;
                            w_res.total_points = r_load_cnt;
                        end else if ({1'b0, w_in.ring} >= w_eff) begin
                            w_res.status = ST_DROP;
                            w_res.total_points = r_load_cnt;
                        end else begin
                            pt_we = 1'b1;
                            ks_we = 1'b1;
                            w_res.total_points = r_load_cnt + CNT_W'(1);
                        end
                    end else if (i_q_entry.cls.is_fin) begin
                        n_state = S_CLR;
                    end else if (i_q_entry.cls.is_pos) begin
                        if ({1'b0, w_in.position} < r_sorted_total) begin
                            si_re   = 1'b1;
                            n_state = S_POS_IDX;
                        end else begin
                            w_emit       = 1'b1;
                            w_res.status = ST_BAD;
                        end
                    end else begin
                        if ({1'b0, w_in.bucket} < w_nb) begin
                            bb_re   = 1'b1;
                            n_state = S_BK_A;
                        end else begin
                            w_emit       = 1'b1;
                            w_res.status = ST_BAD;
                        end
                    end
                end
            end
            S_CLR: begin
                fl_we = 1'b1;
                if (r_b == BK_AW'(NUM_BUCKETS - 1)) begin
                    n_state = S_CNT_KEY;
                end
            end
            S_CNT_KEY: begin
                ks_re = 1'b1;
                if (r_idx == r_load_cnt) begin
                    n_state = S_PFX_RD;
                end else begin
                    n_state = S_CNT_FILL;
                end
            end
            S_CNT_FILL: begin
                fl_re = 1'b1;
                n_state = ({1'b0, ks_rdata} < w_nb) ? S_CNT_WR : S_CNT_KEY;
            end
            S_CNT_WR: begin
                fl_we    = 1'b1;
                fl_waddr = r_k;
                fl_wdata = fl_rdata + CNT_W'(1);
                n_state  = S_CNT_KEY;
            end
            S_PFX_RD: begin
                fl_re   = 1'b1;
                n_state = S_PFX_WR;
            end
            S_PFX_WR: begin
                fl_we    = 1'b1;
                fl_wdata = r_run;
                bb_we    = 1'b1;
                n_state  = (r_b == BK_AW'(NUM_BUCKETS - 1)) ? S_SCT_KEY : S_PFX_RD;
            end
            S_SCT_KEY: begin
                ks_re = 1'b1;
                if (r_idx == r_load_cnt) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_SCT_FILL;
                end
            end
            S_SCT_FILL: begin
                fl_re = 1'b1;
                n_state = ({1'b0, ks_rdata} < w_nb) ? S_SCT_WR : S_SCT_KEY;
            end
            S_SCT_WR: begin
                fl_we    = 1'b1;
                fl_waddr = r_k;
                fl_wdata = fl_rdata + CNT_W'(1);
                si_we    = 1'b1;
                n_state  = S_SCT_KEY;
            end
            S_FIN: begin
                if (w_slot) begin
                    w_emit             = 1'b1;
                    w_res.total_points = r_run;
                    w_res.status       = r_flags[0] ? ST_OVF :
                                         (r_flags[1] ? ST_DROP : ST_OK);
                    n_state            = S_IDLE;
                end
            end
            S_POS_IDX: begin
                pt_re   = 1'b1;
                ks_re   = 1'b1;
                n_state = S_POS_DATA;
            end
            S_POS_DATA: begin
                if (w_slot) begin
                    w_emit             = 1'b1;
                    w_res.point_data   = pt_rdata;
                    w_res.point_bucket = ks_rdata;
                    n_state            = S_IDLE;
                end
            end
            S_BK_A: begin
                bb_re   = 1'b1;
                n_state = S_BK_B;
            end
            S_BK_B: begin
                if (w_slot) begin
                    w_emit            = 1'b1;
                    w_res.range_start = r_start;
                    w_res.range_end   = r_bounds_valid ? bb_rdata : '0;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers and sort counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_rings        <= 7'd16;
            r_load_cnt     <= '0;
            r_sorted_total <= '0;
            r_flags        <= '0;
            r_bounds_valid <= 1'b0;
            r_out_valid    <= 1'b0;
            r_idx          <= '0;
            r_b            <= '0;
            r_run          <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_rings <= i_cfg_data;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state) inside
                S_IDLE: begin
                    r_idx <= '0;
                    r_b   <= '0;
                    r_run <= '0;
                    if (o_q_pop && i_q_entry.cls.is_load) begin
                        if (r_load_cnt >= CNT_W'(MAX_POINTS)) begin
                            r_flags[0] <= 1'b1;
                        end else if ({1'b0, w_in.ring} >= w_eff) begin
                            r_flags[1] <= 1'b1;
                        end else begin
                            r_load_cnt <= r_load_cnt + CNT_W'(1);
                        end
                    end
                end
                S_CLR: begin
                    r_b <= r_b + BK_AW'(1);
                end
                S_CNT_FILL: begin
                    if ({1'b0, ks_rdata} >= w_nb) begin
                        r_flags[1] <= 1'b1;
                        r_idx      <= r_idx + CNT_W'(1);
                    end
                end
                S_CNT_WR, S_SCT_WR: begin
                    r_idx <= r_idx + CNT_W'(1);
                end
                S_PFX_WR: begin
                    r_run <= bb_wdata;
                    r_b   <= r_b + BK_AW'(1);
                    r_idx <= '0;
                end
                S_SCT_FILL: begin
                    if ({1'b0, ks_rdata} >= w_nb) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                end
                S_FIN: begin
                    if (w_slot) begin
                        r_sorted_total <= r_run;
                        r_flags        <= '0;
                        r_load_cnt     <= '0;
                        r_bounds_valid <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= w_in;
        end
        if (r_state == S_CNT_FILL || r_state == S_SCT_FILL) begin
            r_k <= ks_rdata;
        end
        if (r_state == S_BK_A) begin
            r_start <= (r_item.bucket == 7'd0 || !r_bounds_valid) ? '0 : bb_rdata;
        end
        if (w_emit) begin
            r_out <= w_res;
        end
    end

    rasb_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_point_store (
        .i_clk(i_clk), .i_we(pt_we), .i_waddr(pt_waddr), .i_wdata(w_in.payload),
        .i_re(pt_re), .i_raddr(pt_raddr), .o_rdata(pt_rdata)
    );

    rasb_ram #(.WIDTH(BK_AW), .DEPTH(MAX_POINTS)) u_key_store (
        .i_clk(i_clk), .i_we(ks_we), .i_waddr(pt_waddr), .i_wdata(w_key_new),
        .i_re(ks_re), .i_raddr(ks_raddr), .o_rdata(ks_rdata)
    );

    rasb_ram #(.WIDTH(PT_AW), .DEPTH(MAX_POINTS)) u_sorted_index (
        .i_clk(i_clk), .i_we(si_we), .i_waddr(si_waddr), .i_wdata(r_idx[PT_AW-1:0]),
        .i_re(si_re), .i_raddr(si_raddr), .o_rdata(si_rdata)
    );

    rasb_ram #(.WIDTH(CNT_W), .DEPTH(NUM_BUCKETS)) u_bucket_fill (
        .i_clk(i_clk), .i_we(fl_we), .i_waddr(fl_waddr), .i_wdata(fl_wdata),
        .i_re(fl_re), .i_raddr(fl_raddr), .o_rdata(fl_rdata)
    );

    rasb_ram #(.WIDTH(CNT_W), .DEPTH(NUM_BUCKETS)) u_bucket_bounds (
        .i_clk(i_clk), .i_we(bb_we), .i_waddr(r_b), .i_wdata(bb_wdata),
        .i_re(bb_re), .i_raddr(bb_raddr), .o_rdata(bb_rdata)
    );

endmodule

/* src/ring_and_side_bucket_sort.sv */
// Stable counting sort of scan points into ring/side buckets. A load or an
// out-of-range read is answered straight from the idle state; a position read
// or a bucket-range read makes two registered reads of the stores in turn. A
// finish runs a clearing pass over the bucket counters, a count pass and a
// scatter pass per point through the key store and the counter memory, and a
// prefix pass over the buckets; a point that the sort leaves out skips the
// counter writes. A two-entry queue in front lets new commands transfer in
// while the sorter is busy; the bucket table reads as zero until the first
// finish.
module ring_and_side_bucket_sort import rasb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [6:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_item
);

    logic     q_valid;
    logic     q_pop;
    t_q_entry q_entry;

    // Front end: classify and queue commands.
    rasb_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_item(i_in_item),
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_entry(q_entry)
    );

    // Back end: stores, sorter and result register.
    rasb_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_entry(q_entry),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_item(o_out_item)
    );

endmodule

/* sim/ring_and_side_bucket_sort_tb.sv */
module ring_and_side_bucket_sort_tb;
    import rasb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    logic [6:0] i_cfg_data;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    ring_and_side_bucket_sort dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // Shadow copy of the sorter state.
    logic [63:0] shadow_points [MAX_POINTS];
    logic [6:0]  shadow_keys [MAX_POINTS];
    logic [11:0] shadow_order [MAX_POINTS];
    logic [12:0] shadow_bounds [NUM_BUCKETS];
    int unsigned shadow_loads;
    logic [1:0]  shadow_errors;
    int unsigned shadow_sorted;
    logic [6:0]  shadow_rings;

    t_out_item   expected_results [$];
    int          failures;
    int          results_seen;
    int          finishes_seen;
    logic        long_hold;

    // Directed table: item plus an optional typed-in expectation.
    typedef struct {
        t_in_item  item;
        logic      fixed;
        t_out_item result;
    } t_row;

    function automatic int unsigned rings_now();
        return (shadow_rings > MAX_RINGS) ? MAX_RINGS : shadow_rings;
    endfunction

    // Applies one command to the shadow state and returns its answer.
    function automatic t_out_item sort_step(t_in_item it);
        t_out_item   r;
        int unsigned nb, run, skip, p;
        int unsigned fill [NUM_BUCKETS];
        r = '0;
        nb = 2 * rings_now();
        case (it.command)
            CMD_LOAD: begin
                if (shadow_loads >= MAX_POINTS) begin
                    shadow_errors[0] = 1'b1;
                    r.status = ST_OVF;
                end else if (it.ring >= rings_now()) begin
                    shadow_errors[1] = 1'b1;
                    r.status = ST_DROP;
                end else begin
                    shadow_points[shadow_loads] = it.payload;
                    shadow_keys[shadow_loads] = {it.ring, ~it.angle_positive};
                    shadow_loads++;
                end
                r.total_points = 13'(shadow_loads);
            end
            CMD_FIN: begin
                skip = 0;
                run = 0;
                foreach (fill[b]) fill[b] = 0;
                for (int i = 0; i < shadow_loads; i++) begin
                    if (shadow_keys[i] < nb) fill[shadow_keys[i]]++;
                    else skip++;
                end
                for (int b = 0; b < NUM_BUCKETS; b++) begin
                    p = fill[b];
                    fill[b] = run;
                    run += p;
                    shadow_bounds[b] = 13'(run);
                end
                for (int i = 0; i < shadow_loads; i++) begin
                    if (shadow_keys[i] < nb) begin
                        shadow_order[fill[shadow_keys[i]]] = 12'(i);
                        fill[shadow_keys[i]]++;
                    end
                end
                if (skip != 0) shadow_errors[1] = 1'b1;
                shadow_sorted = run;
                r.total_points = 13'(run);
                r.status = shadow_errors[0] ? ST_OVF : (shadow_errors[1] ? ST_DROP : ST_OK);
                shadow_errors = '0;
                shadow_loads = 0;
            end
            CMD_POS: begin
                if (it.position < shadow_sorted) begin
                    r.point_data = shadow_points[shadow_order[it.position]];
                    r.point_bucket = shadow_keys[shadow_order[it.position]];
                end else begin
                    r.status = ST_BAD;
                end
            end
            default: begin
                if (it.bucket < nb) begin
                    r.range_start = (it.bucket == 0) ? 13'd0 : shadow_bounds[it.bucket - 1];
                    r.range_end = shadow_bounds[it.bucket];
                end else begin
                    r.status = ST_BAD;
                end
            end
        endcase
        return r;
    endfunction

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Overall time limit.
    initial begin
        #40ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: random stalls, and one long hold-off counted here once requested.
    initial begin
        int   hold_left;
        logic hold_taken;
        hold_left = 0;
        hold_taken = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = 1500;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if ((results_seen / 64) % 3 == 0) i_out_ready <= 1'b1;
            else i_out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Compare every result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("result with nothing expected");
                failures++;
            end else begin
                want = expected_results.pop_front();
                if (want.point_data !== o_out_item.point_data) begin
                    $error("point_data expected %h actual %h", want.point_data,
                           o_out_item.point_data);
                    failures++;
                end
                if (want.point_bucket !== o_out_item.point_bucket) begin
                    $error("point_bucket expected %0d actual %0d", want.point_bucket,
                           o_out_item.point_bucket);
                    failures++;
                end
                if (want.range_start !== o_out_item.range_start) begin
                    $error("range_start expected %0d actual %0d", want.range_start,
                           o_out_item.range_start);
                    failures++;
                end
                if (want.range_end !== o_out_item.range_end) begin
                    $error("range_end expected %0d actual %0d", want.range_end,
                           o_out_item.range_end);
                    failures++;
                end
                if (want.total_points !== o_out_item.total_points) begin
                    $error("total_points expected %0d actual %0d", want.total_points,
                           o_out_item.total_points);
                    failures++;
                end
                if (want.status !== o_out_item.status) begin
                    $error("status expected %0d actual %0d", want.status,
                           o_out_item.status);
                    failures++;
                end
            end
        end
    end

    // Offer one item and hold it until its transfer.
    task automatic send_item(t_in_item it, logic fixed, t_out_item fixed_result);
        t_out_item r;
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (!o_in_ready);
        r = sort_step(it);
        if (fixed && r !== fixed_result) begin
            $error("table row disagrees with prediction for command %0d", it.command);
            failures++;
        end
        if (it.command == CMD_FIN) finishes_seen++;
        expected_results = {expected_results, (fixed ? fixed_result : r)};
    endtask

    // Random gap after an item; short bursts are handled by the caller.
    task automatic sender_gap();
        int n;
        n = $urandom_range(0, 3);
        if (n != 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Wait for all results, then a settling pause, and write the register.
    task automatic write_rings(logic [6:0] v);
        int guard;
        i_in_valid <= 1'b0;
        guard = 0;
        while (expected_results.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        shadow_rings = v;
    endtask

    function automatic t_in_item random_item(int unsigned ring_top, int load_bias);
        t_in_item it;
        int       pick;
        it.payload = {$urandom, $urandom};
        it.angle_positive = 1'($urandom_range(0, 1));
        it.ring = ($urandom_range(0, 15) == 0) ? 6'($urandom) :
                  6'($urandom_range(0, (ring_top == 0) ? 0 : ring_top - 1));
        pick = $urandom_range(0, 99);
        if (pick < load_bias) it.command = CMD_LOAD;
        else if (pick < load_bias + 3) it.command = CMD_FIN;
        else if (pick < load_bias + 3 + (97 - load_bias) / 2) it.command = CMD_POS;
        else it.command = CMD_BKT;
        it.position = ($urandom_range(0, 7) == 0) ? 12'($urandom) :
                      12'($urandom_range(0, shadow_sorted + 1));
        it.bucket = ($urandom_range(0, 7) == 0) ? 7'($urandom) :
                    7'($urandom_range(0, 2 * rings_now()));
        return it;
    endfunction

    initial begin
        t_row      rows [$];
        t_row      row;
        t_in_item  it;
        t_out_item zr;
        int        guard;
        logic [6:0] ring_settings [6];

        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        long_hold = 1'b0;
        failures = 0;
        results_seen = 0;
        finishes_seen = 0;
        shadow_loads = 0;
        shadow_errors = '0;
        shadow_sorted = 0;
        shadow_rings = 7'd16;
        foreach (shadow_bounds[b]) shadow_bounds[b] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: reads before any finish, extremes and drops.
        zr = '0;
        it = '0; it.command = CMD_BKT; it.bucket = 0;
        row.item = it; row.fixed = 1; row.result = zr; rows = {rows, row};
        it.bucket = 7'd127;
        row.item = it; row.result = zr; row.result.status = ST_BAD; rows = {rows, row};
        it = '0; it.command = CMD_POS; it.position = 0;
        row.item = it; row.result = zr; row.result.status = ST_BAD; rows = {rows, row};
        it = '0; it.command = CMD_LOAD; it.ring = 6'd63; it.payload = '1;
        row.item = it; row.result = zr; row.result.status = ST_DROP; rows = {rows, row};
        it = '0; it.command = CMD_LOAD; it.ring = 6'd15; it.payload = '1;
        row.item = it; row.result = zr; row.result.total_points = 1; rows = {rows, row};
        it = '0; it.command = CMD_LOAD; it.ring = 6'd0; it.angle_positive = 1;
        row.item = it; row.result = zr; row.result.total_points = 2; rows = {rows, row};
        it.payload = 64'h5555_aaaa_0f0f_f0f0; it.angle_positive = 0; it.ring = 6'd7;
        row.item = it; row.fixed = 0; rows = {rows, row};
        it.payload = 64'haaaa_5555_f0f0_0f0f; it.angle_positive = 1;
        rows = {rows, row}; rows[$].item = it;
        it = '0; it.command = CMD_FIN;
        row.item = it; row.fixed = 1; row.result = zr; row.result.total_points = 4;
        row.result.status = ST_DROP; rows = {rows, row};
        row.fixed = 0;
        for (int p = 0; p < 5; p++) begin
            it = '0; it.command = CMD_POS; it.position = 12'(p); it.payload = '1;
            row.item = it; rows = {rows, row};
        end
        foreach (ring_settings[k]) begin
            it = '0; it.command = CMD_BKT; it.bucket = 7'(k * 6);
            row.item = it; rows = {rows, row};
        end
        it = '0; it.command = CMD_POS; it.position = 12'hfff;
        row.item = it; row.fixed = 1; row.result = zr; row.result.status = ST_BAD;
        rows = {rows, row};
        it = '0; it.command = CMD_FIN;
        row.item = it; row.result = zr; rows = {rows, row};

        foreach (rows[k]) send_item(rows[k].item, rows[k].fixed, rows[k].result);

        // Random phases over several ring settings, extremes included.
        ring_settings = '{7'd1, 7'd64, 7'd4, 7'd127, 7'd0, 7'd16};
        foreach (ring_settings[k]) begin
            write_rings(ring_settings[k]);
            for (int n = 0; n < 170; n++) begin
                send_item(random_item(rings_now(), 55), 0, zr);
                if ($urandom_range(0, 4) == 0) sender_gap();
            end
            it = '0; it.command = CMD_FIN;
            send_item(it, 0, zr);
            // Lower the register after loads so that a finish excludes points.
            if (k == 1) begin
                for (int n = 0; n < 20; n++) begin
                    it = random_item(64, 100);
                    send_item(it, 0, zr);
                end
                write_rings(7'd2);
                it = '0; it.command = CMD_FIN;
                send_item(it, 0, zr);
                write_rings(ring_settings[k]);
            end
        end

        // Back-pressure: the receiver holds off for a long stretch while items keep coming.
        write_rings(7'd64);
        long_hold = 1'b1;
        for (int n = 0; n < 40; n++) send_item(random_item(64, 60), 0, zr);
        it = '0; it.command = CMD_FIN;
        send_item(it, 0, zr);
        i_in_valid <= 1'b0;

        guard = 0;
        while (expected_results.size() != 0 && guard < 500000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (50) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            failures++;
        end
        $display("Covered %0d results across %0d sorts, six ring settings and a long stall.",
                 results_seen, finishes_seen);
        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/rasb_pkg.sv
src/rasb_ram.sv
src/rasb_front.sv
src/rasb_back.sv
src/ring_and_side_bucket_sort.sv
sim/ring_and_side_bucket_sort_tb.sv
